/* rtl/assert_macros.svh */
// Assertion macros shared by the thinning block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

/* rtl/bit_pkg.sv */
// Package with constants and types of the thinning block.
package bit_pkg;
	localparam int MAX_WIDTH_DEF = 64;
	localparam int MAX_HEIGHT_DEF = 64;
	localparam int ROW_W = 64;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 7;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

	typedef struct packed {
		logic second;
		logic [MAX_WIDTH_DEF-1:0] mask;
	} cell_ctl_t;
endpackage

/* rtl/bit_if.sv */
// Valid/ready channel interfaces for rows and configuration.
interface bit_row_if;
	logic valid;
	logic ready;
	logic [bit_pkg::ROW_W-1:0] row;
	logic last;
	modport source (output valid, output row, output last, input ready);
	modport sink (input valid, input row, input last, output ready);
endinterface

interface bit_cfg_if;
	logic valid;
	logic ready;
	logic [bit_pkg::CFG_IDX_W-1:0] index;
	logic [bit_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/bit_cell.sv */
// One row cell: holds a row and computes its deletions from its neighbors.
module bit_cell #(
	parameter int W = bit_pkg::MAX_WIDTH_DEF
) (
	input logic clk,
	input logic load,
	input logic [W-1:0] load_row,
	input logic shift,
	input logic [W-1:0] shift_in,
	input logic step,
	input logic [W-1:0] north,
	input logic [W-1:0] south,
	input bit_pkg::cell_ctl_t ctl,
	output logic [W-1:0] row,
	output logic changed
);
	logic [W-1:0] row_q;
	logic [W-1:0] del;
	logic [W-1:0] cur_m, north_m, south_m;

	assign cur_m = row_q & ctl.mask[W-1:0];
	assign north_m = north & ctl.mask[W-1:0];
	assign south_m = south & ctl.mask[W-1:0];

	always_comb begin
		logic [7:0] p;
		logic [3:0] cnt;
		logic [3:0] tr;
		logic ok;
		del = '0;
		for (int c = 0; c < W; c++) begin
			p[0] = north_m[c];
			p[1] = (c + 1 < W) ? north_m[(c + 1) % W] : 1'b0;
			p[2] = (c + 1 < W) ? cur_m[(c + 1) % W] : 1'b0;
			p[3] = (c + 1 < W) ? south_m[(c + 1) % W] : 1'b0;
			p[4] = south_m[c];
			p[5] = (c > 0) ? south_m[(c + W - 1) % W] : 1'b0;
			p[6] = (c > 0) ? cur_m[(c + W - 1) % W] : 1'b0;
			p[7] = (c > 0) ? north_m[(c + W - 1) % W] : 1'b0;
			cnt = '0;
			tr = '0;
			for (int n = 0; n < 8; n++) begin
				cnt = cnt + 4'(p[n]);
				tr = tr + 4'(!p[n] && p[(n + 1) % 8]);
			end
			if (ctl.second)
				ok = !(p[0] & p[2] & p[6]) && !(p[0] & p[4] & p[6]);
			else
				ok = !(p[0] & p[2] & p[4]) && !(p[2] & p[4] & p[6]);
			del[c] = cur_m[c] && tr == 4'd1 && cnt >= 4'd2 && cnt <= 4'd6 && ok;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			row_q <= load_row;
		else if (shift)
			row_q <= shift_in;
		else if (step)
			row_q <= (row_q & ~del) & ctl.mask[W-1:0];
	end

	assign row = row_q;
	assign changed = step && (|del);
endmodule

/* rtl/binary_image_thinning_core.sv */
// Top level: Zhang-Suen thinning over a chain of row cells.
// Loading writes each accepted row into its cell; each sub-pass updates all rows at once.
// After the last row, thinning repeats rounds of both sub-passes until a round deletes nothing.
// Rows then leave one per cycle while the output is not stalled, through the chain, the last flagged.
// Reset clears the row count, control state and sets both size registers to 64.
`include "assert_macros.svh"
module binary_image_thinning_core #(
	parameter int MAX_WIDTH = bit_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bit_pkg::MAX_HEIGHT_DEF
) (
	input logic clk,
	input logic arst_n,
	bit_cfg_if.sink cfg,
	bit_row_if.sink in_ch,
	bit_row_if.source out_ch
);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int RW = bit_pkg::ROW_W;
	typedef enum logic [1:0] {S_LOAD, S_PASS1, S_PASS2, S_EMIT} state_t;

	state_t state_q;
	logic [6:0] width_q, height_q;
	logic [HW-1:0] rows_q, emit_q, h_eff;
	logic [6:0] w_eff;
	logic any_q;
	logic [MAX_WIDTH-1:0] mask;
	logic [MAX_WIDTH-1:0] rows [MAX_HEIGHT];
	logic [MAX_HEIGHT-1:0] chg, load_en;
	logic in_acc, emit_go, step, round_chg;
	bit_pkg::cell_ctl_t ctl;

	always_comb begin
		w_eff = (width_q == 7'd0) ? 7'd1 :
			(32'(width_q) > MAX_WIDTH) ? 7'(MAX_WIDTH) : width_q;
		h_eff = (height_q == 7'd0) ? HW'(1) :
			(32'(height_q) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(height_q);
		for (int c = 0; c < MAX_WIDTH; c++)
			mask[c] = 7'(c) < w_eff;
	end

	assign in_acc = in_ch.valid && in_ch.ready;
	assign in_ch.ready = state_q == S_LOAD;
	assign cfg.ready = 1'b1;
	assign step = state_q == S_PASS1 || state_q == S_PASS2;
	assign emit_go = state_q == S_EMIT && (!out_ch.valid || out_ch.ready);
	assign round_chg = |chg;

	always_comb begin
		ctl.second = state_q == S_PASS2;
		ctl.mask = '0;
		ctl.mask[MAX_WIDTH-1:0] = mask;
	end

	genvar g;
	generate
		for (g = 0; g < MAX_HEIGHT; g++) begin : g_cell
			logic [MAX_WIDTH-1:0] nb_n, nb_s;
			assign load_en[g] = in_acc &&
				((rows_q >= h_eff) ? (h_eff - HW'(1)) : rows_q) == HW'(g);
			assign nb_n = (g == 0) ? '0 : rows[(g + MAX_HEIGHT - 1) % MAX_HEIGHT];
			assign nb_s = (g + 1 >= MAX_HEIGHT || HW'(g + 1) >= h_eff) ? '0 :
				rows[(g + 1) % MAX_HEIGHT];
			bit_cell #(.W(MAX_WIDTH)) u_cell (
				.clk(clk), .load(load_en[g]), .load_row(in_ch.row[MAX_WIDTH-1:0] & mask),
				.shift(emit_go), .shift_in(nb_s), .step(step && HW'(g) < h_eff),
				.north(nb_n), .south(nb_s), .ctl(ctl),
				.row(rows[g]), .changed(chg[g])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			width_q <= 7'd64;
			height_q <= 7'd64;
			rows_q <= '0;
			emit_q <= '0;
			any_q <= 1'b0;
			out_ch.valid <= 1'b0;
			out_ch.last <= 1'b0;
		end else begin
			if (cfg.valid) begin
				if (cfg.index == bit_pkg::REG_WIDTH) width_q <= cfg.data;
				else height_q <= cfg.data;
			end
			if (out_ch.valid && out_ch.ready && !emit_go) out_ch.valid <= 1'b0;
			unique case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						if (rows_q + HW'(1) >= h_eff) begin
							state_q <= S_PASS1;
							rows_q <= '0;
						end else begin
							rows_q <= rows_q + HW'(1);
						end
					end
				end
				S_PASS1: begin
					any_q <= round_chg;
					state_q <= S_PASS2;
				end
				S_PASS2: begin
					if (any_q || round_chg) state_q <= S_PASS1;
					else begin
						state_q <= S_EMIT;
						emit_q <= '0;
					end
					any_q <= 1'b0;
				end
				S_EMIT: begin
					if (emit_go) begin
						out_ch.valid <= 1'b1;
						out_ch.row <= RW'(rows[0] & mask);
						out_ch.last <= emit_q + HW'(1) == h_eff;
						emit_q <= emit_q + HW'(1);
						if (emit_q + HW'(1) == h_eff) state_q <= S_LOAD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	`ASSERT_IMPL(a_no_in_busy, clk, arst_n, state_q != S_LOAD, !in_ch.ready, "input taken while busy")
	`ASSERT_IMPL(a_emit_bound, clk, arst_n, state_q == S_EMIT, emit_q < h_eff, "emit count overrun")
	`ASSERT_NEXT(a_pass_order, clk, arst_n, state_q == S_PASS1, state_q == S_PASS2, "pass order broken")
endmodule

/* tb/binary_image_thinning_core_tb.sv */
// Self-checking testbench for the Zhang-Suen thinning core with a row-level skeleton predictor.
module binary_image_thinning_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [bit_pkg::ROW_W-1:0] row;
		logic last;
	} skel_row_t;

	logic clk;
	logic arst_n;
	bit_cfg_if cfg();
	bit_row_if in_ch();
	bit_row_if out_ch();

	binary_image_thinning_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg.sink),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	logic [bit_pkg::ROW_W-1:0] rows_q[$];
	skel_row_t skel_q[$];
	logic [bit_pkg::ROW_W-1:0] img[bit_pkg::MAX_HEIGHT_DEF];
	int rows_in;
	int width_reg = 64;
	int height_reg = 64;
	int errors = 0;
	int in_gap = 0;
	int out_stall = 0;
	int hold_left = 0;
	int press_req = 0;
	int press_done = 0;
	bit quiet = 0;

	function automatic int clamp_size(int v);
		if (v < 1) return 1;
		if (v > 64) return 64;
		return v;
	endfunction

	function automatic bit pix(int r, int c, int h, int w);
		if (r < 0 || c < 0 || r >= h || c >= w) return 0;
		return img[r][c];
	endfunction

	function automatic bit thin_pass(int h, int w, bit second);
		logic [bit_pkg::ROW_W-1:0] del[bit_pkg::MAX_HEIGHT_DEF];
		bit p[8];
		int cnt, trans;
		bit ok, any;
		any = 0;
		for (int r = 0; r < h; r++) begin
			del[r] = '0;
			for (int c = 0; c < w; c++) begin
				if (!img[r][c]) continue;
				p[0] = pix(r - 1, c, h, w);
				p[1] = pix(r - 1, c + 1, h, w);
				p[2] = pix(r, c + 1, h, w);
				p[3] = pix(r + 1, c + 1, h, w);
				p[4] = pix(r + 1, c, h, w);
				p[5] = pix(r + 1, c - 1, h, w);
				p[6] = pix(r, c - 1, h, w);
				p[7] = pix(r - 1, c - 1, h, w);
				cnt = 0;
				trans = 0;
				for (int n = 0; n < 8; n++) begin
					cnt += p[n];
					if (!p[n] && p[(n + 1) % 8]) trans++;
				end
				if (second)
					ok = !(p[0] & p[2] & p[6]) && !(p[0] & p[4] & p[6]);
				else
					ok = !(p[0] & p[2] & p[4]) && !(p[2] & p[4] & p[6]);
				if (trans == 1 && cnt >= 2 && cnt <= 6 && ok) begin
					del[r][c] = 1'b1;
					any = 1;
				end
			end
		end
		for (int r = 0; r < h; r++) img[r] &= ~del[r];
		return any;
	endfunction

	function automatic void load_row(logic [bit_pkg::ROW_W-1:0] row);
		int h, w, idx;
		logic [bit_pkg::ROW_W-1:0] mask;
		bit changed;
		skel_row_t s;
		h = clamp_size(height_reg);
		w = clamp_size(width_reg);
		mask = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
		idx = (rows_in >= h) ? h - 1 : rows_in;
		img[idx] = row & mask;
		rows_in = (idx + 1) & 127;
		if (idx + 1 < h) return;
		for (int r = 0; r < h; r++) img[r] &= mask;
		do begin
			changed = thin_pass(h, w, 0);
			changed |= thin_pass(h, w, 1);
		end while (changed);
		for (int r = 0; r < h; r++) begin
			s.row = img[r];
			s.last = (r + 1 == h);
			skel_q.push_back(s);
		end
		rows_in = 0;
	endfunction

	function automatic logic [bit_pkg::ROW_W-1:0] rand_row();
		logic [bit_pkg::ROW_W-1:0] v;
		int lo, hi;
		v = {$urandom, $urandom};
		case ($urandom_range(4))
			0: return v;
			1: return v & {$urandom, $urandom};
			2: return '1;
			3: return '0;
			default: begin
				lo = $urandom_range(0, 40);
				hi = $urandom_range(lo, 63);
				return ((hi == 63) ? '1 : ((64'd1 << (hi + 1)) - 64'd1)) & ~((64'd1 << lo) - 64'd1);
			end
		endcase
	endfunction

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("binary_image_thinning_core regression: fail");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.row <= '0;
			in_ch.last <= 1'b0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (in_ch.valid) load_row(in_ch.row);
			if (in_gap > 0) begin
				in_gap--;
				in_ch.valid <= 1'b0;
			end else if (rows_q.size() > 0 && (quiet || $urandom_range(7) != 0)) begin
				in_ch.row <= rows_q.pop_front();
				in_ch.valid <= 1'b1;
			end else begin
				in_ch.valid <= 1'b0;
				if (!quiet && rows_q.size() > 0) in_gap = $urandom_range(4);
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (skel_q.size() == 0) begin
					$display("%0t: unexpected transaction, actual row %h last %b",
						$time, out_ch.row, out_ch.last);
					errors++;
				end else begin
					if (out_ch.row !== skel_q[0].row || out_ch.last !== skel_q[0].last) begin
						$display("%0t: expected row %h last %b, actual row %h last %b", $time,
							skel_q[0].row, skel_q[0].last, out_ch.row, out_ch.last);
						errors++;
					end
					void'(skel_q.pop_front());
				end
			end
			if (press_req != press_done) begin
				press_done = press_req;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else if (out_stall > 0) begin
				out_stall--;
				out_ch.ready <= 1'b0;
			end else if (!quiet && $urandom_range(7) == 0) begin
				out_stall = $urandom_range(0, 4);
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	task automatic write_reg(logic [bit_pkg::CFG_IDX_W-1:0] idx, int value);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value[bit_pkg::CFG_DATA_W-1:0];
		forever begin
			@(negedge clk);
			if (cfg.ready) break;
		end
		@(posedge clk);
		cfg.valid <= 1'b0;
		if (idx == bit_pkg::REG_WIDTH) width_reg = value & 127;
		else height_reg = value & 127;
	endtask

	task automatic drain();
		forever begin
			@(negedge clk);
			if (rows_q.size() == 0 && !in_ch.valid && skel_q.size() == 0) break;
		end
		repeat (10) @(negedge clk);
	endtask

	task automatic send_rows(int n);
		for (int i = 0; i < n; i++) rows_q.push_back(rand_row());
	endtask

	initial begin
		int sent;
		int h;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_reg(bit_pkg::REG_WIDTH, 1);
		write_reg(bit_pkg::REG_HEIGHT, 1);
		rows_q.push_back('1);
		drain();
		write_reg(bit_pkg::REG_WIDTH, 0);
		write_reg(bit_pkg::REG_HEIGHT, 0);
		rows_q.push_back({$urandom, $urandom});
		drain();
		write_reg(bit_pkg::REG_WIDTH, 127);
		write_reg(bit_pkg::REG_HEIGHT, 3);
		repeat (3) rows_q.push_back('1);
		drain();
		write_reg(bit_pkg::REG_WIDTH, 8);
		write_reg(bit_pkg::REG_HEIGHT, 5);
		rows_q.push_back('0);
		rows_q.push_back(64'h3c);
		rows_q.push_back(64'hff);
		rows_q.push_back(64'h7e);
		rows_q.push_back(64'h18);
		drain();
		write_reg(bit_pkg::REG_HEIGHT, 8);
		send_rows(3);
		drain();
		write_reg(bit_pkg::REG_HEIGHT, 2);
		rows_q.push_back('1);
		drain();
		write_reg(bit_pkg::REG_WIDTH, 64);
		write_reg(bit_pkg::REG_HEIGHT, 4);
		send_rows(2);
		drain();
		write_reg(bit_pkg::REG_WIDTH, 5);
		send_rows(2);
		drain();

		sent = 0;
		while (sent < 310) begin
			if (sent > 240) quiet = 1;
			if (sent > 120 && press_req == 0) begin
				write_reg(bit_pkg::REG_WIDTH, $urandom_range(3, 16));
				write_reg(bit_pkg::REG_HEIGHT, 3);
				press_req++;
				send_rows(24);
				sent += 24;
			end else if (sent > 60 && sent < 90) begin
				write_reg(bit_pkg::REG_WIDTH, 64);
				write_reg(bit_pkg::REG_HEIGHT, 64);
				send_rows(64);
				sent += 64;
			end else begin
				write_reg(bit_pkg::REG_WIDTH, ($urandom_range(9) == 0) ? 64 : $urandom_range(2, 20));
				h = $urandom_range(2, 8);
				write_reg(bit_pkg::REG_HEIGHT, h);
				h = h * $urandom_range(1, 3);
				send_rows(h);
				sent += h;
			end
			drain();
		end
		drain();
		if (errors == 0) begin
			$display("binary_image_thinning_core regression: pass");
		end else begin
			$display("binary_image_thinning_core regression: fail");
		end
		$finish;
	end
endmodule
